>>> rtl/core/ksib_pkg.sv
// Shared types and codes for the k-mer segment index builder.
`timescale 1ns / 1ps
`default_nettype none
package ksib_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_COUNT    = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_PLACE    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PLACE = 2'd0,
    KIND_TOTAL = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic REG_K_LEN      = 1'b0;
  localparam logic REG_GENOME_LEN = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_READ,
    ST_SWEEP,
    ST_TOTAL
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/ksib_if.sv
// Valid/ready channels carrying input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ksib_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  base_code;
  logic [15:0] table_index;

  modport source (output valid, operation, base_code, table_index, input ready);
  modport sink (input valid, operation, base_code, table_index, output ready);
endinterface

interface ksib_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] entry_address;
  logic [31:0] segment_id;
  logic [31:0] word_value;

  modport source (output valid, result_kind, entry_address, segment_id, word_value,
                  input ready);
  modport sink (input valid, result_kind, entry_address, segment_id, word_value,
                output ready);
endinterface
`default_nettype wire

>>> rtl/core/ksib_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ksib_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/kmer_segment_index_builder.sv
// Top level of the k-mer segment index builder: control, window and table memories.
//
// Items arrive on the valid/ready channel "items" and results leave on "results";
// a beat moves when valid and ready are high at a rising edge of clk. Configuration
// (k_len at index 0, genome_length at index 1) is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, and the block itself
// does not enforce this. A count or place base whose window is dropped only moves
// the window and position; otherwise the code's count and tag are read from the table
// memories as it is taken, then the tag is checked and both are written back. A read
// returns the registered count-table word. Finalize sweeps all 4^MAX_K table rows at
// one row a cycle, prefixing the first 4^k counts and clearing every tag, then sends
// the total beat; the sweep length is set by the single write port of the tag memory.
// After rst the same sweep clears both memories; items are not taken during it, though
// configuration writes are. Results sit in an output register; if the receiver
// stalls, an item with a result to send waits until the register frees, and only
// then is the next item taken.
`timescale 1ns / 1ps
`default_nettype none
module kmer_segment_index_builder #(
  parameter int MAX_K   = 8,
  parameter int SEG_LEN = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  ksib_item_if.sink        items,
  ksib_result_if.source    results
);

  localparam int AW    = 2 * MAX_K;
  localparam int DEPTH = 1 << AW;
  localparam int OFF_W = (SEG_LEN > 1) ? $clog2(SEG_LEN) : 1;
  localparam int DW    = OFF_W + 6;

  // Registers
  ksib_pkg::state_t state, state_next;
  logic [3:0]       k_len;
  logic [31:0]      genome_length;
  logic [AW-1:0]    window;
  logic [31:0]      position;
  logic [31:0]      pos_seg;
  logic [OFF_W-1:0] pos_off;
  logic [31:0]      running_total;
  logic             place_q;
  logic [AW-1:0]    code_q;
  logic [31:0]      seg_q;
  logic             fin_q;
  logic [AW:0]      idx;
  logic             out_valid;
  logic [1:0]       out_kind;
  logic [31:0]      out_addr;
  logic [31:0]      out_seg;
  logic [31:0]      out_word;

  // Memory ports
  logic          cnt_we, cnt_re, tag_we, tag_re;
  logic [AW-1:0] cnt_waddr, cnt_raddr, tag_waddr;
  logic [31:0]   cnt_wdata, cnt_rdata;
  logic [32:0]   tag_wdata, tag_rdata;

  // Datapath signals
  logic             acc, out_free, first, out_load;
  logic [3:0]       k_eff;
  logic [AW-1:0]    win_new, kmask, code;
  logic [32:0]      pos1, p;
  logic [DW-1:0]    off_sum, off_p;
  logic [31:0]      seg_p;
  logic [33:0]      seg_end;
  logic             win_ok;
  logic [AW:0]      idx_m1, n_ent;

  assign acc      = items.valid && items.ready;
  assign out_free = !out_valid || results.ready;
  assign items.ready = (state == ksib_pkg::ST_IDLE);

  // Clamp k and build the code mask
  always_comb begin
    if (k_len == 4'd0) begin
      k_eff = 4'd1;
    end else if (k_len > 4'(MAX_K)) begin
      k_eff = 4'(MAX_K);
    end else begin
      k_eff = k_len;
    end
    for (int b = 0; b < AW; b++) begin
      kmask[b] = (b < 2 * int'(k_eff));
    end
  end

  // Window start, its segment and acceptance
  always_comb begin
    win_new = {window[AW-3:0], items.base_code};
    code    = win_new & kmask;
    pos1    = {1'b0, position} + 33'd1;
    p       = pos1 - 33'(k_eff);
    off_sum = DW'(pos_off) + DW'(1);
    off_p   = off_sum - DW'(k_eff);
    seg_p   = pos_seg;
    if (off_sum < DW'(k_eff)) begin
      for (int j = 1; j <= MAX_K; j++) begin
        if (DW'(k_eff) - off_sum == DW'(j)) begin
          off_p = DW'(((j + SEG_LEN - 1) / SEG_LEN) * SEG_LEN - j);
          seg_p = pos_seg - 32'((j + SEG_LEN - 1) / SEG_LEN);
        end
      end
    end
    seg_end = {1'b0, p} - 34'(off_p) + 34'(SEG_LEN);
    win_ok  = (pos1 >= 33'(k_eff)) && (pos1 <= {1'b0, genome_length})
              && (seg_end <= {2'b0, genome_length});
  end

  assign first  = !(tag_rdata[32] && (tag_rdata[31:0] == seg_q));
  assign idx_m1 = idx - (AW+1)'(1);
  assign n_ent  = (AW+1)'(1) << (2 * k_eff);

  // Load the output register with a new beat
  assign out_load = out_free
                    && ((state == ksib_pkg::ST_BASE && place_q && first)
                        || state == ksib_pkg::ST_READ
                        || state == ksib_pkg::ST_TOTAL);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ksib_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (ksib_pkg::op_t'(items.operation))
            ksib_pkg::OP_COUNT, ksib_pkg::OP_PLACE: begin
              if (win_ok) state_next = ksib_pkg::ST_BASE;
            end
            ksib_pkg::OP_FINALIZE: state_next = ksib_pkg::ST_SWEEP;
            ksib_pkg::OP_READ:     state_next = ksib_pkg::ST_READ;
            default:               state_next = ksib_pkg::ST_IDLE;
          endcase
        end
      end
      ksib_pkg::ST_BASE: begin
        if (!(place_q && first) || out_free) state_next = ksib_pkg::ST_IDLE;
      end
      ksib_pkg::ST_READ: begin
        if (out_free) state_next = ksib_pkg::ST_IDLE;
      end
      ksib_pkg::ST_SWEEP: begin
        if (idx == (AW+1)'(DEPTH)) begin
          state_next = fin_q ? ksib_pkg::ST_TOTAL : ksib_pkg::ST_IDLE;
        end
      end
      ksib_pkg::ST_TOTAL: begin
        if (out_free) state_next = ksib_pkg::ST_IDLE;
      end
      default: state_next = ksib_pkg::ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    tag_we    = 1'b0;
    tag_re    = 1'b0;
    cnt_waddr = code_q;
    cnt_raddr = code;
    tag_waddr = code_q;
    cnt_wdata = cnt_rdata + 32'd1;
    tag_wdata = {1'b1, seg_q};
    unique case (state)
      ksib_pkg::ST_IDLE: begin
        if (acc) begin
          if ((items.operation == ksib_pkg::OP_COUNT || items.operation == ksib_pkg::OP_PLACE)
              && win_ok) begin
            cnt_re = 1'b1;
            tag_re = 1'b1;
          end else if (items.operation == ksib_pkg::OP_READ) begin
            cnt_re    = 1'b1;
            cnt_raddr = AW'(items.table_index);
          end
        end
      end
      ksib_pkg::ST_BASE: begin
        if (first && (!place_q || out_free)) begin
          cnt_we = 1'b1;
          tag_we = 1'b1;
        end
      end
      ksib_pkg::ST_SWEEP: begin
        cnt_raddr = idx[AW-1:0];
        tag_waddr = idx[AW-1:0];
        tag_wdata = '0;
        cnt_waddr = idx_m1[AW-1:0];
        cnt_wdata = fin_q ? running_total : 32'd0;
        if (idx != (AW+1)'(DEPTH)) begin
          cnt_re = 1'b1;
          tag_we = 1'b1;
        end
        if (idx != '0 && (!fin_q || idx_m1 < n_ent)) cnt_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_len         <= 4'd8;
      genome_length <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ksib_pkg::REG_K_LEN) k_len <= cfg_data[3:0];
      else genome_length <= cfg_data;
    end
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ksib_pkg::ST_SWEEP;
      idx           <= '0;
      fin_q         <= 1'b0;
      window        <= '0;
      position      <= '0;
      pos_seg       <= '0;
      pos_off       <= '0;
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && !results.ready);
      unique case (state)
        ksib_pkg::ST_IDLE: begin
          if (acc) begin
            if (items.operation == ksib_pkg::OP_COUNT
                || items.operation == ksib_pkg::OP_PLACE) begin
              // advance window and position tracking
              window   <= win_new;
              position <= position + 32'd1;
              if (position == '1) begin
                pos_seg <= '0;
                pos_off <= '0;
              end else if (32'(pos_off) + 32'd1 == 32'(SEG_LEN)) begin
                pos_off <= '0;
                pos_seg <= pos_seg + 32'd1;
              end else begin
                pos_off <= pos_off + OFF_W'(1);
              end
              place_q <= (items.operation == ksib_pkg::OP_PLACE);
              code_q  <= code;
              seg_q   <= seg_p;
            end else if (items.operation == ksib_pkg::OP_FINALIZE) begin
              // rewind the stream and start the sweep
              window        <= '0;
              position      <= '0;
              pos_seg       <= '0;
              pos_off       <= '0;
              running_total <= '0;
              idx           <= '0;
              fin_q         <= 1'b1;
            end
          end
        end
        ksib_pkg::ST_BASE: begin
          if (place_q && first && out_free) begin
            out_kind  <= ksib_pkg::KIND_PLACE;
            out_addr  <= cnt_rdata;
            out_seg   <= seg_q;
            out_word  <= '0;
          end
        end
        ksib_pkg::ST_READ: begin
          if (out_free) begin
            out_kind  <= ksib_pkg::KIND_READ;
            out_addr  <= '0;
            out_seg   <= '0;
            out_word  <= cnt_rdata;
          end
        end
        ksib_pkg::ST_SWEEP: begin
          if (fin_q && idx != '0 && idx_m1 < n_ent) begin
            running_total <= running_total + cnt_rdata;
          end
          if (idx != (AW+1)'(DEPTH)) idx <= idx + (AW+1)'(1);
        end
        ksib_pkg::ST_TOTAL: begin
          if (out_free) begin
            out_kind  <= ksib_pkg::KIND_TOTAL;
            out_addr  <= '0;
            out_seg   <= '0;
            out_word  <= running_total;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign results.valid         = out_valid;
  assign results.result_kind   = out_kind;
  assign results.entry_address = out_addr;
  assign results.segment_id    = out_seg;
  assign results.word_value    = out_word;

  // Count table
  ksib_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Last-segment tags, valid bit on top
  ksib_ram #(.WIDTH(33), .DEPTH(DEPTH)) u_tag (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (code),
    .rdata (tag_rdata)
  );

endmodule
`default_nettype wire

>>> bench/tb_kmer_segment_index_builder.sv
// Self-checking bench for the k-mer segment index builder: count, finalize, place and read.
`timescale 1ns / 1ps
module tb_kmer_segment_index_builder;

  localparam int SEG        = 256;
  localparam int DEPTH      = 65536;
  localparam int CYCLE_CAP  = 30000000;
  localparam int SETTLE_CYC = 12;

  typedef struct packed {
    ksib_pkg::kind_t kind;
    logic [31:0]     addr;
    logic [31:0]     seg;
    logic [31:0]     word;
  } index_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  ksib_item_if   items ();
  ksib_result_if results ();

  kmer_segment_index_builder DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .items    (items),
    .results  (results)
  );

  // Shadow copy of the index state
  logic [31:0] offset_mem [DEPTH];
  bit          tag_live   [DEPTH];
  logic [31:0] tag_seg    [DEPTH];
  logic [15:0] kmer_window;
  logic [31:0] stream_pos;
  logic [31:0] entry_total;
  logic [3:0]  k_reg;
  logic [31:0] genome_len;

  index_result_t pending_q [$];
  int          mismatches;
  int          cycles;
  bit          pace_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[kmer_segment_index_builder] ERROR");
      $finish;
    end
  end

  function automatic int k_eff();
    if (k_reg < 4'd1) return 1;
    if (k_reg > 4'd8) return 8;
    return int'(k_reg);
  endfunction

  // Shift a base into the window; report a first occurrence in its segment
  function automatic bit shift_base(input logic [1:0] b, output logic [15:0] code,
                                    output logic [31:0] seg);
    int           k;
    logic [63:0]  pos1;
    logic [63:0]  start;
    logic [63:0]  full_len;
    logic [15:0]  kmask;
    k        = k_eff();
    kmask    = 16'((32'd1 << (2 * k)) - 1);
    pos1     = 64'(stream_pos) + 64'd1;
    full_len = (64'(genome_len) / SEG) * SEG;
    kmer_window = {kmer_window[13:0], b};
    stream_pos  = stream_pos + 32'd1;
    code = '0;
    seg  = '0;
    if (pos1 < 64'(k)) return 1'b0;
    start = pos1 - 64'(k);
    if (start + 64'(k) > 64'(genome_len)) return 1'b0;
    if (start >= full_len) return 1'b0;
    code = kmer_window & kmask;
    seg  = 32'(start / SEG);
    if (tag_live[code] && tag_seg[code] == seg) return 1'b0;
    tag_live[code] = 1'b1;
    tag_seg[code]  = seg;
    return 1'b1;
  endfunction

  function automatic void rewind_stream();
    for (int i = 0; i < DEPTH; i++) begin
      tag_live[i] = 1'b0;
      tag_seg[i]  = '0;
    end
    kmer_window = '0;
    stream_pos  = '0;
  endfunction

  // Work out the result (if any) of one accepted item
  function automatic void predict_item(ksib_pkg::op_t op, logic [1:0] b, logic [15:0] idx);
    logic [15:0]   code;
    logic [31:0]   seg;
    logic [31:0]   t;
    int            n;
    index_result_t r;
    r = '0;
    case (op)
      ksib_pkg::OP_COUNT: begin
        if (shift_base(b, code, seg)) offset_mem[code] = offset_mem[code] + 32'd1;
      end
      ksib_pkg::OP_FINALIZE: begin
        n = 1 << (2 * k_eff());
        entry_total = '0;
        for (int i = 0; i < n; i++) begin
          t = offset_mem[i];
          offset_mem[i] = entry_total;
          entry_total = entry_total + t;
        end
        rewind_stream();
        r.kind = ksib_pkg::KIND_TOTAL;
        r.word = entry_total;
        pending_q.push_back(r);
      end
      ksib_pkg::OP_PLACE: begin
        if (shift_base(b, code, seg)) begin
          r.kind = ksib_pkg::KIND_PLACE;
          r.addr = offset_mem[code];
          r.seg  = seg;
          pending_q.push_back(r);
          offset_mem[code] = offset_mem[code] + 32'd1;
        end
      end
      default: begin
        r.kind = ksib_pkg::KIND_READ;
        r.word = offset_mem[idx];
        pending_q.push_back(r);
      end
    endcase
  endfunction

  // Result side: random stalls, then check each beat against the oldest expectation
  initial begin
    int            stall;
    index_result_t got;
    index_result_t want;
    results.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = pace_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
      got.kind = ksib_pkg::kind_t'(results.result_kind);
      got.addr = results.entry_address;
      got.seg  = results.segment_id;
      got.word = results.word_value;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: kind %0d addr %0d seg %0d word %0d",
                   got.kind, got.addr, got.seg, got.word);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: exp kind %0d addr %0d seg %0d word %0d, ",
                      "got kind %0d addr %0d seg %0d word %0d"},
                     want.kind, want.addr, want.seg, want.word,
                     got.kind, got.addr, got.seg, got.word);
        end
      end
    end
  end

  // Send one item and predict it once accepted
  task automatic send_item(ksib_pkg::op_t op, logic [1:0] b, logic [15:0] idx);
    int gap;
    gap = pace_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.valid       <= 1'b1;
    items.operation   <= op;
    items.base_code   <= b;
    items.table_index <= idx;
    do @(posedge clk); while (!items.ready);
    predict_item(op, b, idx);
  endtask

  // Let the block drain before touching configuration
  task automatic drain();
    items.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ksib_pkg::REG_K_LEN) k_reg = val[3:0];
    else genome_len = val;
    @(posedge clk);
  endtask

  task automatic send_bases(ksib_pkg::op_t op, int n);
    for (int i = 0; i < n; i++) send_item(op, 2'($urandom), 16'($urandom));
  endtask

  task automatic send_reads(int n);
    for (int i = 0; i < n; i++) send_item(ksib_pkg::OP_READ, 2'($urandom), 16'($urandom));
  endtask

  // Reads and a finalize at reset k, then k = 1 with no genome, then one full segment and a partial tail
  task automatic test_directed();
    pace_on = 1'b0;
    send_item(ksib_pkg::OP_READ, 2'd0, 16'h0000);
    send_item(ksib_pkg::OP_READ, 2'd3, 16'hFFFF);
    send_item(ksib_pkg::OP_FINALIZE, 2'd0, 16'h0000);
    drain();
    write_reg(ksib_pkg::REG_K_LEN, 32'd1);
    write_reg(ksib_pkg::REG_GENOME_LEN, 32'd0);
    // nothing complete: every window is dropped
    send_item(ksib_pkg::OP_COUNT, 2'd0, 16'h0000);
    send_item(ksib_pkg::OP_PLACE, 2'd3, 16'h0000);
    drain();
    write_reg(ksib_pkg::REG_GENOME_LEN, 32'(SEG + 3));
    send_item(ksib_pkg::OP_COUNT, 2'd0, 16'h0000);
    send_item(ksib_pkg::OP_COUNT, 2'd1, 16'h0000);
    send_item(ksib_pkg::OP_COUNT, 2'd2, 16'h0000);
    send_item(ksib_pkg::OP_COUNT, 2'd3, 16'h0000);
    send_item(ksib_pkg::OP_COUNT, 2'd3, 16'h0000);
    send_item(ksib_pkg::OP_FINALIZE, 2'd0, 16'h0000);
    send_item(ksib_pkg::OP_PLACE, 2'd3, 16'h0000);
    send_item(ksib_pkg::OP_PLACE, 2'd3, 16'h0000);
    send_item(ksib_pkg::OP_PLACE, 2'd0, 16'h0000);
    send_item(ksib_pkg::OP_READ, 2'd0, 16'h0003);
    send_item(ksib_pkg::OP_READ, 2'd0, 16'h0000);
    drain();
  endtask

  // Full count / finalize / place sequence with random content
  task automatic test_index_pass(logic [3:0] k, logic [31:0] glen, int nbases, int nreads);
    pace_on = ($urandom_range(0, 3) != 0);
    write_reg(ksib_pkg::REG_K_LEN, 32'(k));
    write_reg(ksib_pkg::REG_GENOME_LEN, glen);
    send_bases(ksib_pkg::OP_COUNT, nbases);
    send_item(ksib_pkg::OP_FINALIZE, 2'($urandom), 16'($urandom));
    send_bases(ksib_pkg::OP_PLACE, nbases);
    send_reads(nreads);
    drain();
  endtask

  // Random mix of operations, finalize kept rare
  task automatic test_noise(int n);
    ksib_pkg::op_t op;
    pace_on = 1'b1;
    write_reg(ksib_pkg::REG_K_LEN, 32'd0);
    write_reg(ksib_pkg::REG_GENOME_LEN, $urandom);
    for (int i = 0; i < n; i++) begin
      op = ksib_pkg::op_t'($urandom_range(0, 3));
      if (op == ksib_pkg::OP_FINALIZE && $urandom_range(0, 7) != 0) op = ksib_pkg::OP_READ;
      send_item(op, 2'($urandom), 16'($urandom));
    end
    send_item(ksib_pkg::OP_FINALIZE, 2'd0, 16'h0000);
    send_reads(8);
    drain();
  endtask

  initial begin
    mismatches = 0;
    cycles     = 0;
    pace_on    = 1'b0;
    for (int i = 0; i < DEPTH; i++) offset_mem[i] = '0;
    rewind_stream();
    entry_total = '0;
    k_reg       = 4'd8;
    genome_len  = '0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = ksib_pkg::REG_K_LEN;
    cfg_data          = '0;
    items.valid       = 1'b0;
    items.operation   = ksib_pkg::OP_COUNT;
    items.base_code   = '0;
    items.table_index = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_index_pass(4'd3, 32'(SEG + 14), SEG + 24, 20);
    test_index_pass(4'd15, 32'hFFFF_FFFF, 40, 10);
    test_noise(90);

    if (mismatches == 0) begin
      $display("[kmer_segment_index_builder] OK");
    end else begin
      $display("[kmer_segment_index_builder] ERROR");
    end
    $finish;
  end

endmodule
